// File: sv/ctb_pkg.sv
// Shared types and constants for the CSMA transmit backoff controller.
// No dependencies; used by the interfaces and all modules.
package ctb_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned SeqW  = 8;
  localparam int unsigned RndW  = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_MIN_BACKOFF  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_BACKOFF  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_RETRY    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SEND_PROB    = 2'd3;

  // reset values
  localparam logic [7:0]  MIN_BACKOFF_RST = 8'd8;
  localparam logic [15:0] MAX_BACKOFF_RST = 16'd255;
  localparam logic [3:0]  MAX_RETRY_RST   = 4'd3;
  localparam logic [8:0]  SEND_PROB_RST   = 9'd256;

  // result status codes
  localparam logic [2:0] ST_IGNORED_PENDING = 3'd0;
  localparam logic [2:0] ST_BACKOFF_STARTED = 3'd1;
  localparam logic [2:0] ST_SUCCESS         = 3'd2;
  localparam logic [2:0] ST_RETRY_BACKOFF   = 3'd3;
  localparam logic [2:0] ST_GAVE_UP         = 3'd4;
  localparam logic [2:0] ST_NOACK_RETRY     = 3'd5;
  localparam logic [2:0] ST_IDLE_IGNORED    = 3'd6;

  // command codes
  localparam logic CMD_SEND    = 1'b0;
  localparam logic CMD_EXPIRED = 1'b1;

  typedef struct packed {
    logic            command;
    logic            ack_wanted;
    logic [RndW-1:0] random_backoff;
    logic [RndW-1:0] random_send;
    logic            channel_clear;
    logic            tx_ok;
    logic            ack_seen;
    logic [SeqW-1:0] ack_sequence;
    logic            clear_statistics;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic            transmit;
    logic [SeqW-1:0] frame_sequence;
    logic            tmr_load;
    logic [15:0]     timer_interval;
    logic [CntW-1:0] send_count;
    logic [CntW-1:0] fail_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  min_backoff;
    logic [15:0] max_backoff;
    logic [3:0]  max_retry;
    logic [8:0]  send_probability;
  } cfg_t;

endpackage

// File: sv/ctb_in_if.sv
// Input channel: valid/ready handshake carrying one event item.
// Depends on ctb_pkg.
interface ctb_in_if
  import ctb_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ctb_out_if.sv
// Output channel: valid/ready handshake carrying one result item.
// Depends on ctb_pkg.
interface ctb_out_if
  import ctb_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/csma_transmit_backoff_controller_top.sv
// CSMA transmit backoff controller, top level.
// Events arrive on in_ch (valid/ready). command 0 is a send request, command 1
// reports that the backoff timer expired and asks for a transmit attempt along
// with the channel, random and acknowledgement results for that attempt.
// Each event gives exactly one result on out_ch: a status code, the transmit
// flag, the frame sequence, an optional timer start with its interval and the
// send/failure counters.
// Path: an item accepted from in_ch lands in the input register; its result is
// computed from that register and stored in the output register, from which
// it is offered on out_ch.
// Throughput: one item per cycle unless out_ch stalls; each event is one pass
// through the state update, a 17x8 backoff multiply and a few compares.
// When out_ch stalls, the output register holds its result and the input
// register holds the next item; in_ch.ready drops only when both are full.
// Reset (rst_ni low, asynchronous) empties both registers, returns the
// controller to idle with zeroed counters and sequence, and loads the register
// defaults. The user must write configuration via cfg_we_i/cfg_idx_i/cfg_data_i
// only while no item is in flight; the block itself does not enforce this.
// Depends on ctb_pkg, ctb_in_if, ctb_out_if, ctb_cfg, ctb_core.
module csma_transmit_backoff_controller_top
  import ctb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  ctb_in_if.sink              in_ch,
  ctb_out_if.source           out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_vld_q;
  out_item_t res;
  out_item_t res_q;
  logic      res_vld_q;
  logic      step;
  logic      in_rdy;

  ctb_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  ctb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .item_i (item_q),
    .res_o  (res)
  );

  // item moves from input register to output register
  assign step   = item_vld_q && (!res_vld_q || out_ch.ready);
  assign in_rdy = !item_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_rdy) begin
        item_vld_q <= in_ch.valid;
      end
      if (step) begin
        res_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_ch.valid) begin
      item_q <= in_ch.data;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = res_vld_q;
  assign out_ch.data  = res_q;

endmodule

// File: sv/ctb_cfg.sv
// Configuration register file: backoff limits, retry limit, send probability.
// Depends on ctb_pkg.
module ctb_cfg
  import ctb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_backoff      <= MIN_BACKOFF_RST;
      cfg_q.max_backoff      <= MAX_BACKOFF_RST;
      cfg_q.max_retry        <= MAX_RETRY_RST;
      cfg_q.send_probability <= SEND_PROB_RST;
    end else if (we_i) begin
      case (idx_i)
        REG_MIN_BACKOFF: cfg_q.min_backoff      <= data_i[7:0];
        REG_MAX_BACKOFF: cfg_q.max_backoff      <= data_i[15:0];
        REG_MAX_RETRY:   cfg_q.max_retry        <= data_i[3:0];
        REG_SEND_PROB:   cfg_q.send_probability <= data_i[8:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/ctb_core.sv
// Controller state and per-event next-state/result logic.
// Depends on ctb_pkg. State advances when step_i is high.
module ctb_core
  import ctb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  logic            in_backoff_q, in_backoff_d;
  logic [3:0]      retry_q, retry_d;
  logic [15:0]     backoff_q, backoff_d;
  logic [SeqW-1:0] seq_q, seq_d;
  logic            ack_mode_q, ack_mode_d;
  logic [CntW-1:0] sends_q, sends_d;
  logic [CntW-1:0] drops_q, drops_d;

  logic [16:0] draw_n;
  logic [24:0] prod;
  logic [17:0] nb;
  logic [15:0] nb_capped;
  logic        gate;
  logic        ok;
  out_item_t   res;

  // one shared multiplier: initial draw uses max_backoff, retry uses 2*backoff
  assign draw_n    = (item_i.command == CMD_SEND) ? {1'b0, cfg_i.max_backoff}
                                                  : {backoff_q, 1'b0};
  assign prod      = draw_n * {9'd0, item_i.random_backoff};
  assign nb        = {1'b0, prod[24:8]} + {10'd0, cfg_i.min_backoff};
  assign nb_capped = (nb > {2'b00, cfg_i.max_backoff}) ? cfg_i.max_backoff : nb[15:0];

  assign gate = item_i.channel_clear &&
                ({1'b0, item_i.random_send} < cfg_i.send_probability);
  assign ok   = ack_mode_q ? (gate && item_i.ack_seen && (item_i.ack_sequence == seq_q))
                           : (gate && item_i.tx_ok);

  always_comb begin
    in_backoff_d = in_backoff_q;
    retry_d      = retry_q;
    backoff_d    = backoff_q;
    seq_d        = seq_q;
    ack_mode_d   = ack_mode_q;
    sends_d      = sends_q;
    drops_d      = drops_q;

    res                = '0;
    res.frame_sequence = seq_q;
    res.status         = ST_IGNORED_PENDING;

    if (item_i.command == CMD_SEND) begin
      if (!in_backoff_q) begin
        ack_mode_d         = item_i.ack_wanted;
        sends_d            = sends_q + 1'b1;
        backoff_d          = nb[15:0];
        retry_d            = '0;
        in_backoff_d       = 1'b1;
        res.status         = ST_BACKOFF_STARTED;
        res.tmr_load       = 1'b1;
        res.timer_interval = nb[15:0];
      end
    end else if (!in_backoff_q) begin
      res.status = ST_IDLE_IGNORED;
    end else begin
      res.transmit = gate;
      if (ok) begin
        seq_d        = seq_q + 1'b1;
        retry_d      = '0;
        in_backoff_d = 1'b0;
        res.status   = ST_SUCCESS;
      end else if (ack_mode_q) begin
        if (retry_q >= cfg_i.max_retry) begin
          retry_d      = '0;
          in_backoff_d = 1'b0;
          drops_d      = drops_q + 1'b1;
          res.status   = ST_GAVE_UP;
        end else begin
          retry_d            = retry_q + 1'b1;
          backoff_d          = nb_capped;
          res.status         = ST_RETRY_BACKOFF;
          res.tmr_load       = 1'b1;
          res.timer_interval = nb_capped;
        end
      end else begin
        res.status = ST_NOACK_RETRY;
      end
    end

    // counters are reported after this event, then cleared on request
    res.send_count = sends_d;
    res.fail_count = drops_d;
    if (item_i.clear_statistics) begin
      sends_d = '0;
      drops_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_backoff_q <= 1'b0;
      retry_q      <= '0;
      backoff_q    <= {8'd0, MIN_BACKOFF_RST};
      seq_q        <= '0;
      ack_mode_q   <= 1'b0;
      sends_q      <= '0;
      drops_q      <= '0;
    end else if (step_i) begin
      in_backoff_q <= in_backoff_d;
      retry_q      <= retry_d;
      backoff_q    <= backoff_d;
      seq_q        <= seq_d;
      ack_mode_q   <= ack_mode_d;
      sends_q      <= sends_d;
      drops_q      <= drops_d;
    end
  end

  assign res_o = res;

endmodule
